>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define QMEF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define QMEF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/qmef_pkg.sv
// ---------------------------------------------------------------------------
// qmef_pkg
// Field widths, codes and constants of the quad mesh neighbor finder.
// ---------------------------------------------------------------------------
package qmef_pkg;

  localparam int EDGES       = 4;
  localparam int HIT_W       = 4;
  localparam int INDEX_W     = 10;
  localparam int NODE_W      = 16;
  localparam int NEIGHBOR_W  = 11;
  localparam int COUNT_W     = 11;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_W   = 1;

  localparam logic [HIT_W-1:0]      HIT_COUNT   = 4'd2;
  localparam logic [NEIGHBOR_W-1:0] NO_NEIGHBOR = 11'h7FF;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CELL_COUNT = 1'b0;

endpackage

>>> design/qmef_in_if.sv
// ---------------------------------------------------------------------------
// qmef_in_if
// Request channel: load or query of one cell.
// ---------------------------------------------------------------------------
interface qmef_in_if import qmef_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              mode;
  logic [INDEX_W-1:0] cell_index;
  logic [NODE_W-1:0]  node_first;
  logic [NODE_W-1:0]  node_second;
  logic [NODE_W-1:0]  node_third;
  logic [NODE_W-1:0]  node_fourth;

  modport source (
    output valid, mode, cell_index, node_first, node_second, node_third, node_fourth,
    input  ready
  );

  modport sink (
    input  valid, mode, cell_index, node_first, node_second, node_third, node_fourth,
    output ready
  );

endinterface

>>> design/qmef_out_if.sv
// ---------------------------------------------------------------------------
// qmef_out_if
// Result channel: the neighbor across each edge of a queried cell, edges a to d.
// ---------------------------------------------------------------------------
interface qmef_out_if import qmef_pkg::*; ();

  logic                         valid;
  logic                         ready;
  logic signed [NEIGHBOR_W-1:0] neighbor_edge_a;
  logic signed [NEIGHBOR_W-1:0] neighbor_edge_b;
  logic signed [NEIGHBOR_W-1:0] neighbor_edge_c;
  logic signed [NEIGHBOR_W-1:0] neighbor_edge_d;

  modport source (
    output valid, neighbor_edge_a, neighbor_edge_b, neighbor_edge_c, neighbor_edge_d,
    input  ready
  );

  modport sink (
    input  valid, neighbor_edge_a, neighbor_edge_b, neighbor_edge_c, neighbor_edge_d,
    output ready
  );

endinterface

>>> design/qmef_match.sv
// ---------------------------------------------------------------------------
// qmef_match
// Edge match unit: counts node hits of one stored cell against each edge of the queried quad.
// ---------------------------------------------------------------------------
module qmef_match import qmef_pkg::*; #(
  parameter int ID_W = 16
) (
  input  logic [EDGES-1:0][ID_W-1:0] row,
  input  logic [EDGES-1:0][ID_W-1:0] nodes,
  output logic [EDGES-1:0]           edge_hit
);

  logic [HIT_W-1:0] cnt [EDGES];

  // Edge e runs from vertex e to vertex e+1, wrapping.
  always_comb begin
    for (int e = 0; e < EDGES; e++) begin
      cnt[e] = '0;
      for (int t = 0; t < EDGES; t++) begin
        cnt[e] = cnt[e] + HIT_W'(row[t] == nodes[e])
                        + HIT_W'(row[t] == nodes[(e + 1) % EDGES]);
      end
      edge_hit[e] = (cnt[e] == HIT_COUNT);
    end
  end

endmodule

>>> design/quad_mesh_edge_neighbor_finder.sv
// ---------------------------------------------------------------------------
// quad_mesh_edge_neighbor_finder
// Cell table with a sequential edge-adjacency search over stored quads.
// ---------------------------------------------------------------------------
// Usage:
//   in_req  (valid/ready): mode 0 loads four node ids into cell cell_index
//           and gives no result; mode 1 queries cell cell_index.
//   out_rsp (valid/ready): one result per query, the neighbor across each
//           edge (a: v0-v1, b: v1-v2, c: v2-v3, d: v3-v0), -1 when none.
//   APB port: register 0 (byte address 0) is cell_count, the scan length.
// Query steps:
//   With n = min(cell_count, MAX_CELLS), a query does one read of the queried
//   cell, one table read for each of the n scanned cells through the single
//   memory read port, a compare in the match unit that trails each read, and
//   a last step to leave the scan. A load leaves the sequencer idle. A query
//   of an index >= MAX_CELLS answers -1 without a scan. in_req is ready only
//   while idle; one request is in flight at a time.
// Reset: clears the sequencer and cell_count. The table is not cleared; a
//   cell must be loaded before it is queried or scanned.
// Stall: the result stays in its output register until taken, and no new
//   request is accepted until then.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quad_mesh_edge_neighbor_finder import qmef_pkg::*; #(
  parameter int MAX_CELLS    = 1024,
  parameter int NODE_ID_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  qmef_in_if.sink               in_req,
  qmef_out_if.source            out_rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Table address, scan counter and helper widths.
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam int YW = (AW > NEIGHBOR_W) ? AW : NEIGHBOR_W;
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

  typedef logic [EDGES-1:0][NODE_ID_BITS-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SELF,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    cell_count_r;
  logic [CW-1:0]         j_r, j_nxt;
  logic [CW-1:0]         limit_r, limit_nxt;
  logic [AW-1:0]         self_r, self_nxt;
  row_t                  q_r, q_nxt;
  logic [NEIGHBOR_W-1:0] found_r   [EDGES];
  logic [NEIGHBOR_W-1:0] found_nxt [EDGES];
  logic                  scan_vld_r, scan_vld_nxt;
  logic [AW-1:0]         scan_idx_r, scan_idx_nxt;

  // Cell table: one port, registered read.
  row_t                  mem [MAX_CELLS];
  row_t                  mem_q_r;
  row_t                  mem_wdata;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;

  logic                  in_acc;
  logic                  out_acc;
  logic                  idx_ok;
  logic [XW-1:0]         idx_x;
  logic [AW-1:0]         idx_a;
  logic                  issue;
  logic [LW-1:0]         cc_x, max_x, lim_x;
  logic [CW-1:0]         lim;
  logic [YW-1:0]         scan_idx_y;
  logic [EDGES-1:0]      edge_hit;
  logic [31:0]           n0_x, n1_x, n2_x, n3_x;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;

  // ---- APB register ------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite & pready & (cfg_idx == CFG_IDX_CELL_COUNT);
  assign prdata  = (cfg_idx == CFG_IDX_CELL_COUNT) ? 32'(cell_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r <= '0;
    end else if (cfg_we) begin
      cell_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  // ---- request decode ----------------------------------------------------
  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid & in_req.ready;
  assign out_acc      = out_rsp.valid & out_rsp.ready;
  assign idx_ok       = 32'(in_req.cell_index) < 32'(MAX_CELLS);
  assign idx_x        = XW'(in_req.cell_index);
  assign idx_a        = idx_x[AW-1:0];

  // Node ids are cut (or zero-extended) to the stored id width.
  assign n0_x = 32'(in_req.node_first);
  assign n1_x = 32'(in_req.node_second);
  assign n2_x = 32'(in_req.node_third);
  assign n3_x = 32'(in_req.node_fourth);
  assign mem_wdata = {n3_x[NODE_ID_BITS-1:0], n2_x[NODE_ID_BITS-1:0],
                      n1_x[NODE_ID_BITS-1:0], n0_x[NODE_ID_BITS-1:0]};

  // Scan length saturates at the table depth.
  assign cc_x  = LW'(cell_count_r);
  assign max_x = LW'(MAX_CELLS);
  assign lim_x = (cc_x > max_x) ? max_x : cc_x;
  assign lim   = lim_x[CW-1:0];

  // ---- table port ----------------------------------------------------------
  assign issue    = (state_r == S_SCAN) && (j_r < limit_r);
  assign mem_we   = in_acc && (in_req.mode == MODE_LOAD) && idx_ok;
  assign mem_re   = (in_acc && (in_req.mode == MODE_QUERY) && idx_ok) || issue;
  assign mem_addr = issue ? j_r[AW-1:0] : idx_a;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // ---- shared match unit ---------------------------------------------------
  qmef_match #(
    .ID_W (NODE_ID_BITS)
  ) u_match (
    .row      (mem_q_r),
    .nodes    (q_r),
    .edge_hit (edge_hit)
  );

  assign scan_idx_y = YW'(scan_idx_r);

  // ---- sequencer -------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    j_nxt        = j_r;
    limit_nxt    = limit_r;
    self_nxt     = self_r;
    q_nxt        = q_r;
    found_nxt    = found_r;
    scan_vld_nxt = issue;
    scan_idx_nxt = j_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_req.mode == MODE_QUERY)) begin
          for (int e = 0; e < EDGES; e++) begin
            found_nxt[e] = NO_NEIGHBOR;
          end
          limit_nxt = lim;
          self_nxt  = idx_a;
          j_nxt     = '0;
          state_nxt = idx_ok ? S_SELF : S_OUT;
        end
      end
      S_SELF: begin
        // Queried cell's ids are on the read register now.
        q_nxt     = mem_q_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (issue) begin
          j_nxt = j_r + CW'(1);
        end
        // Compare works on the row read in the cycle before; later hits overwrite earlier.
        if (scan_vld_r && (scan_idx_r != self_r)) begin
          for (int e = 0; e < EDGES; e++) begin
            if (edge_hit[e]) begin
              found_nxt[e] = scan_idx_y[NEIGHBOR_W-1:0];
            end
          end
        end
        if (!issue && !scan_vld_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    limit_r    <= limit_nxt;
    self_r     <= self_nxt;
    q_r        <= q_nxt;
    found_r    <= found_nxt;
    scan_idx_r <= scan_idx_nxt;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= scan_vld_nxt;
    end
  end

  // ---- result --------------------------------------------------------------
  assign out_rsp.valid           = (state_r == S_OUT);
  assign out_rsp.neighbor_edge_a = found_r[0];
  assign out_rsp.neighbor_edge_b = found_r[1];
  assign out_rsp.neighbor_edge_c = found_r[2];
  assign out_rsp.neighbor_edge_d = found_r[3];

  // ---- assertions ----------------------------------------------------------
  `QMEF_ASSERT_IMPLY(a_ready_no_result, clk, rst_n, in_req.ready, !out_rsp.valid)
  `QMEF_ASSERT_IMPLY(a_compare_in_scan, clk, rst_n, scan_vld_r, state_r == S_SCAN)
  `QMEF_ASSERT_IMPLY(a_scan_bound, clk, rst_n, state_r == S_SCAN, j_r <= limit_r)
  `QMEF_ASSERT_NEXT(a_query_busy, clk, rst_n,
    in_acc && (in_req.mode == MODE_QUERY), !in_req.ready)

endmodule

>>> verif/quad_mesh_edge_neighbor_finder_test.sv
// ---------------------------------------------------------------------------
// quad_mesh_edge_neighbor_finder_test
// Self-checking bench for the quad mesh edge neighbor finder. Loads and
// queries go in through a queue-fed driver. A scoreboard keeps its own copy
// of the cell table and of cell_count, predicts the edge neighbors (a to d) of
// every accepted query and checks each result, field by field, in order.
// The stimulus is a short directed part, then phases of mesh-shaped random
// traffic under several cell_count settings and several idle patterns.
// ---------------------------------------------------------------------------
module quad_mesh_edge_neighbor_finder_test;
  import qmef_pkg::*;

  localparam int CELL_CAP   = 1024;
  localparam int STALL_LIMIT = 20000;  // cycles with no request or result moving
  localparam int DRAIN_WAIT = 1100;    // longer than the longest query
  localparam int IDLE_PAUSE = 8;
  localparam int LONG_HOLD  = 400;

  localparam logic [CFG_ADDR_W-1:0] ADDR_CELL_COUNT = {CFG_IDX_CELL_COUNT, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNMAPPED   = {~CFG_IDX_CELL_COUNT, 2'b00};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_plan_t;

  typedef struct packed {
    logic               mode;
    logic [INDEX_W-1:0] cell_index;
    logic [NODE_W-1:0]  node_first;
    logic [NODE_W-1:0]  node_second;
    logic [NODE_W-1:0]  node_third;
    logic [NODE_W-1:0]  node_fourth;
  } cell_request_t;

  typedef struct packed {
    logic signed [NEIGHBOR_W-1:0] edge_a;
    logic signed [NEIGHBOR_W-1:0] edge_b;
    logic signed [NEIGHBOR_W-1:0] edge_c;
    logic signed [NEIGHBOR_W-1:0] edge_d;
  } neighbor_set_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  qmef_in_if  in_req();
  qmef_out_if out_rsp();

  quad_mesh_edge_neighbor_finder #(
    .MAX_CELLS   (CELL_CAP),
    .NODE_ID_BITS(NODE_W)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Stimulus side: requests waiting for the driver, plus the generator's view
  // of which cells already hold ids (so nothing unwritten is ever read).
  cell_request_t pending_requests[$];
  bit            cell_loaded[CELL_CAP];
  int            loaded_cells[$];

  // Scoreboard side: mirror of the cell table and of cell_count, updated only
  // when the block actually takes a request or a register write.
  logic [NODE_W-1:0]  cell_nodes[CELL_CAP][EDGES];
  logic [COUNT_W-1:0] scan_count;
  neighbor_set_t      expected_neighbors[$];
  int                 fail_count;

  idle_plan_t idle_mode;
  logic       long_hold_request;
  logic       long_hold_taken;
  int         long_hold_left;
  int         quiet_cycles;

  // -------------------------------------------------------------------------
  // Clock
  // -------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // -------------------------------------------------------------------------
  // Neighbor prediction
  // -------------------------------------------------------------------------
  // Highest scanned cell (other than self) whose vertices hit the edge's two
  // nodes exactly twice in total; equal edge nodes count each vertex twice.
  function automatic logic signed [NEIGHBOR_W-1:0] shared_edge_owner(
    int self, logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb);
    int span;
    int hits;
    logic signed [NEIGHBOR_W-1:0] owner;
    span  = (scan_count > CELL_CAP) ? CELL_CAP : int'(scan_count);
    owner = NO_NEIGHBOR;
    for (int j = 0; j < span; j++) begin
      if (j != self) begin
        hits = 0;
        for (int t = 0; t < EDGES; t++) begin
          if (cell_nodes[j][t] == na) hits++;
          if (cell_nodes[j][t] == nb) hits++;
        end
        if (hits == HIT_COUNT) owner = NEIGHBOR_W'(j);
      end
    end
    return owner;
  endfunction

  // Edge k runs from vertex k to vertex k+1, wrapping at the last vertex.
  function automatic neighbor_set_t predict_neighbors(int idx);
    logic signed [NEIGHBOR_W-1:0] owner[EDGES];
    neighbor_set_t res;
    for (int k = 0; k < EDGES; k++)
      owner[k] = shared_edge_owner(idx, cell_nodes[idx][k], cell_nodes[idx][(k + 1) % EDGES]);
    res.edge_a = owner[0];
    res.edge_b = owner[1];
    res.edge_c = owner[2];
    res.edge_d = owner[3];
    return res;
  endfunction

  function automatic int check_field(string name, logic signed [NEIGHBOR_W-1:0] want,
                                     logic signed [NEIGHBOR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // -------------------------------------------------------------------------
  // Idle patterns
  // -------------------------------------------------------------------------
  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:   return $urandom_range(0, 99) < 16;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 65;
      IDLE_BOTH:     return $urandom_range(0, 99) < 16;
      default:       return 1'b0;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Request driver: holds a request until taken, then maybe pulls the next
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cell_request_t nxt;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || in_req.ready) begin
      if (pending_requests.size() != 0 && !sender_gap()) begin
        nxt = pending_requests.pop_front();
        in_req.mode        <= nxt.mode;
        in_req.cell_index  <= nxt.cell_index;
        in_req.node_first  <= nxt.node_first;
        in_req.node_second <= nxt.node_second;
        in_req.node_third  <= nxt.node_third;
        in_req.node_fourth <= nxt.node_fourth;
        in_req.valid       <= 1'b1;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off, counted here, to fill the block and back up
  // the request side while the driver keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold_left  <= 0;
      long_hold_taken <= 1'b0;
    end else if (long_hold_request && !long_hold_taken) begin
      long_hold_left  <= LONG_HOLD;
      long_hold_taken <= 1'b1;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= !(long_hold_left != 0 || receiver_stall());
    end
  end

  // -------------------------------------------------------------------------
  // Monitor and scoreboard
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    neighbor_set_t got;
    neighbor_set_t want;
    if (rst_n) begin
      if (in_req.valid && in_req.ready) begin
        if (in_req.mode == MODE_LOAD) begin
          cell_nodes[in_req.cell_index][0] = in_req.node_first;
          cell_nodes[in_req.cell_index][1] = in_req.node_second;
          cell_nodes[in_req.cell_index][2] = in_req.node_third;
          cell_nodes[in_req.cell_index][3] = in_req.node_fourth;
        end else begin
          expected_neighbors.insert(expected_neighbors.size(),
                                    predict_neighbors(int'(in_req.cell_index)));
        end
      end
      if (out_rsp.valid && out_rsp.ready) begin
        got.edge_a = out_rsp.neighbor_edge_a;
        got.edge_b = out_rsp.neighbor_edge_b;
        got.edge_c = out_rsp.neighbor_edge_c;
        got.edge_d = out_rsp.neighbor_edge_d;
        if (expected_neighbors.size() == 0) begin
          $error("result with no query outstanding: %0d %0d %0d %0d",
                 got.edge_a, got.edge_b, got.edge_c, got.edge_d);
          fail_count++;
        end else begin
          want = expected_neighbors.pop_front();
          fail_count += check_field("neighbor_edge_a", want.edge_a, got.edge_a);
          fail_count += check_field("neighbor_edge_b", want.edge_b, got.edge_b);
          fail_count += check_field("neighbor_edge_c", want.edge_c, got.edge_c);
          fail_count += check_field("neighbor_edge_d", want.edge_d, got.edge_d);
        end
      end
    end
  end

  // Watchdog: a healthy run never goes this long without moving something.
  always @(posedge clk) begin
    if (!rst_n || (in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_load(int idx, logic [NODE_W-1:0] v0, logic [NODE_W-1:0] v1,
                           logic [NODE_W-1:0] v2, logic [NODE_W-1:0] v3);
    cell_request_t req;
    req.mode        = MODE_LOAD;
    req.cell_index  = INDEX_W'(idx);
    req.node_first  = v0;
    req.node_second = v1;
    req.node_third  = v2;
    req.node_fourth = v3;
    pending_requests.insert(pending_requests.size(), req);
    if (!cell_loaded[idx]) begin
      cell_loaded[idx] = 1'b1;
      loaded_cells.insert(loaded_cells.size(), idx);
    end
  endtask

  task automatic push_query(int idx);
    cell_request_t req;
    req = '0;
    req.mode       = MODE_QUERY;
    req.cell_index = INDEX_W'(idx);
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // Cell at grid position pos of a structured quad mesh, width cells across;
  // vertex order is rotated and sometimes reversed so every edge slot sees
  // shared edges.
  task automatic push_mesh_cell(int idx, int pos, logic [NODE_W-1:0] base, int width);
    int r;
    int c;
    int rot;
    logic [NODE_W-1:0] v[EDGES];
    logic [NODE_W-1:0] w[EDGES];
    r    = pos / width;
    c    = pos % width;
    v[0] = NODE_W'(base + r * (width + 1) + c);
    v[1] = NODE_W'(v[0] + 1);
    v[2] = NODE_W'(v[1] + width + 1);
    v[3] = NODE_W'(v[0] + width + 1);
    rot  = $urandom_range(0, EDGES - 1);
    for (int k = 0; k < EDGES; k++) w[k] = v[(k + rot) % EDGES];
    if ($urandom_range(0, 1) == 1) push_load(idx, w[3], w[2], w[1], w[0]);
    else push_load(idx, w[0], w[1], w[2], w[3]);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[CFG_ADDR_W-1:2] == CFG_IDX_CELL_COUNT) scan_count = data[COUNT_W-1:0];
  endtask

  // Block idle: nothing queued, nothing offered, no result outstanding.
  // Checked mid-cycle so the driver's updates at the edge have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_req.valid || expected_neighbors.size() != 0);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // One random phase: new cell_count, full load of the scanned range as a
  // mesh, then mostly queries mixed with mesh rewrites, near-mesh cells
  // (repeated and shared ids) and plain noise.
  task automatic run_phase(int span, idle_plan_t plan, int n_random, bit squeeze);
    int width;
    int pick;
    int idx;
    logic [NODE_W-1:0] base;
    wait_idle();
    cfg_write(ADDR_CELL_COUNT, span);
    idle_mode <= plan;
    width = $urandom_range(1, 8);
    base  = NODE_W'($urandom);
    for (int i = 0; i < span; i++) push_mesh_cell(i, i, base, width);
    for (int n = 0; n < n_random; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (span > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, span - 1);
        else idx = loaded_cells[$urandom_range(0, loaded_cells.size() - 1)];
        push_query(idx);
      end else if (pick < 80) begin
        idx = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, CELL_CAP - 1);
        push_mesh_cell(idx, idx, base, width);
      end else if (pick < 92) begin
        idx = (span > 0 && $urandom_range(0, 1) == 1) ? $urandom_range(0, span - 1)
                                                      : $urandom_range(0, CELL_CAP - 1);
        push_load(idx, NODE_W'(base + $urandom_range(0, 2 * width + 2)),
                  NODE_W'(base + $urandom_range(0, 2 * width + 2)),
                  NODE_W'(base + $urandom_range(0, 2 * width + 2)),
                  NODE_W'(base + $urandom_range(0, 2 * width + 2)));
      end else begin
        push_load($urandom_range(0, CELL_CAP - 1), NODE_W'($urandom), NODE_W'($urandom),
                  NODE_W'($urandom), NODE_W'($urandom));
      end
    end
    if (squeeze) long_hold_request <= 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    long_hold_request = 1'b0;
    idle_mode         = IDLE_NONE;
    scan_count        = '0;
    fail_count        = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // cell_count at reset value zero: nothing scanned, all edges -1.
    push_load(CELL_CAP - 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_load(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_query(CELL_CAP - 1);
    push_query(0);

    // Write to an unmapped register index must leave cell_count alone.
    wait_idle();
    cfg_write(ADDR_UNMAPPED, 32'd8);
    push_query(0);

    // Hand-built eight-cell patch: cell 0 gets a neighbor on every edge, cell 5
    // repeats a node, cell 6 has all-ones ids, cell 7 all zeros.
    wait_idle();
    cfg_write(ADDR_CELL_COUNT, 32'd8);
    push_load(0, 16'd1, 16'd2, 16'd3, 16'd4);
    push_load(1, 16'd2, 16'd1, 16'd5, 16'd6);
    push_load(2, 16'd3, 16'd2, 16'd7, 16'd8);
    push_load(3, 16'd4, 16'd3, 16'd9, 16'd9);
    push_load(4, 16'd1, 16'd4, 16'd10, 16'd11);
    push_load(5, 16'd1, 16'd1, 16'd12, 16'd13);
    push_load(6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_load(7, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_query(0);
    push_query(3);
    push_query(5);
    push_query(6);
    push_query(7);
    push_query(CELL_CAP - 1);  // loaded, but above cell_count

    // Random phases over several scan lengths and idle patterns.
    run_phase(1,  IDLE_NONE,     30, 1'b0);
    run_phase(16, IDLE_SENDER,   50, 1'b0);
    run_phase(40, IDLE_RECEIVER, 50, 1'b0);
    run_phase(48, IDLE_BOTH,     60, 1'b0);
    run_phase(2,  IDLE_NONE,     40, 1'b0);
    run_phase(0,  IDLE_RECEIVER, 30, 1'b0);
    run_phase(60, IDLE_SENDER,   50, 1'b0);
    run_phase(24, IDLE_NONE,     60, 1'b1);  // long receiver hold-off

    // Drain, then give the block time to show any stray result.
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_req.valid || expected_neighbors.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && expected_neighbors.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/qmef_pkg.sv
design/qmef_in_if.sv
design/qmef_out_if.sv
design/qmef_match.sv
design/quad_mesh_edge_neighbor_finder.sv
verif/quad_mesh_edge_neighbor_finder_test.sv
